>>> sv/smf_pkg.sv
// ----------------------------------------------------------------------------
// smf_pkg
// Shared types and constants for the sliding median filter.
// ----------------------------------------------------------------------------
package smf_pkg;

    // Sample and median width
    localparam int SAMPLE_W  = 24;
    // Window size register width and its reset value
    localparam int CFG_W     = 5;
    localparam int CFG_RESET = 5;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic        [CFG_W-1:0]    t_cfg;

endpackage

>>> sv/smf_window.sv
// ----------------------------------------------------------------------------
// smf_window
// Sample shift line: newest sample in tap 0, oldest in the last tap.
// ----------------------------------------------------------------------------
module smf_window import smf_pkg::*; #(
    parameter int MAX_WINDOW = 16
) (
    input  logic                         i_clk,
    input  logic                         i_shift,
    input  t_sample                      i_sample,
    output t_sample [MAX_WINDOW-1:0]     o_taps
);

    t_sample [MAX_WINDOW-1:0] r_taps;

    // Advance the line by one sample on every accepted transfer
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_taps[0] <= i_sample;
            for (int i = 1; i < MAX_WINDOW; i++) begin
                r_taps[i] <= r_taps[i-1];
            end
        end
    end

    assign o_taps = r_taps;

endmodule

>>> sv/smf_rank.sv
// ----------------------------------------------------------------------------
// smf_rank
// Shared rank unit: compares one candidate tap against the active window,
// registers the greater/equal flags, then counts them and checks whether the
// candidate covers the two wanted sorted positions.
// ----------------------------------------------------------------------------
module smf_rank import smf_pkg::*; #(
    parameter int MAX_WINDOW = 16,
    parameter int KW         = 5,
    parameter int IW         = 4
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_issue,
    input  logic [IW-1:0]            i_idx,
    input  logic [KW-1:0]            i_k,
    input  logic [KW-1:0]            i_pos_a,
    input  logic [KW-1:0]            i_pos_b,
    input  t_sample [MAX_WINDOW-1:0] i_taps,
    output logic                     o_vld,
    output t_sample                  o_value,
    output logic                     o_hit_a,
    output logic                     o_hit_b
);

    logic                  r_vld;
    t_sample               r_cand;
    logic [MAX_WINDOW-1:0] r_gt_vec;
    logic [MAX_WINDOW-1:0] r_eq_vec;

    t_sample               n_cand;
    logic [MAX_WINDOW-1:0] n_gt_vec;
    logic [MAX_WINDOW-1:0] n_eq_vec;
    logic [KW:0]           gt_cnt;
    logic [KW:0]           top_cnt;

    // Compare the selected candidate against every tap inside the window
    always_comb begin
        n_cand = i_taps[i_idx];
        for (int j = 0; j < MAX_WINDOW; j++) begin
            if (j < int'(i_k)) begin
                n_gt_vec[j] = $signed(i_taps[j]) > $signed(n_cand);
                n_eq_vec[j] = $signed(i_taps[j]) == $signed(n_cand);
            end else begin
                n_gt_vec[j] = 1'b0;
                n_eq_vec[j] = 1'b0;
            end
        end
    end

    // Hold the compare flags for the counting stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_issue;
        end
        if (i_issue) begin
            r_cand   <= n_cand;
            r_gt_vec <= n_gt_vec;
            r_eq_vec <= n_eq_vec;
        end
    end

    // Candidate occupies sorted positions gt .. gt+eq-1 (descending order)
    always_comb begin
        gt_cnt  = (KW+1)'($countones(r_gt_vec));
        top_cnt = gt_cnt + (KW+1)'($countones(r_eq_vec));
        o_hit_a = (gt_cnt <= {1'b0, i_pos_a}) && ({1'b0, i_pos_a} < top_cnt);
        o_hit_b = (gt_cnt <= {1'b0, i_pos_b}) && ({1'b0, i_pos_b} < top_cnt);
    end

    assign o_vld   = r_vld;
    assign o_value = r_cand;

endmodule

>>> sv/sliding_median_filter.sv
// ----------------------------------------------------------------------------
// sliding_median_filter
// Median of the newest window_size samples of a sequence, by rank selection.
// ----------------------------------------------------------------------------
//  channel   | dir | signals                         | contents
//  ----------+-----+---------------------------------+---------------------------
//  s_axis    | in  | tvalid tready tdata[23:0] tlast | sample, end_of_sequence
//  m_axis    | out | tvalid tready tdata[23:0] tlast | median, last
//  cfg       | in  | i_cfg_wr_en i_cfg_wr_data[4:0]  | window_size
//
//  An item that yields a median is accepted, one rank unit ranks one window
//  tap per cycle over k taps (k = clamped window size), the count stage ends,
//  and the result loads once the output register is free. Other items return
//  to idle. Input is taken only when the sequencer is idle; a finished median
//  waits in the output register, and the next item may be accepted meanwhile.
//  Reset is synchronous, active low; the sample line has no reset.
// ----------------------------------------------------------------------------
module sliding_median_filter import smf_pkg::*; #(
    parameter int MAX_WINDOW = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic [CFG_W-1:0]    i_cfg_wr_data,  // window_size
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [SAMPLE_W-1:0] s_axis_tdata,   // [23:0] sample
    input  logic                s_axis_tlast,   // end_of_sequence
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [SAMPLE_W-1:0] m_axis_tdata,   // [23:0] median
    output logic                m_axis_tlast    // last
);

    localparam int KW = $clog2(MAX_WINDOW + 1);
    localparam int IW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_DONE
    } t_state;

    function automatic logic [KW-1:0] f_clamp(input t_cfg ws);
        int v;
        v = int'(ws);
        if (v < 1) v = 1;
        if (v > MAX_WINDOW) v = MAX_WINDOW;
        return KW'(v);
    endfunction

    t_state         r_state,   n_state;
    t_cfg           r_wsize,   n_wsize;
    logic [KW-1:0]  r_fill,    n_fill;
    logic [KW-1:0]  r_k,       n_k;
    logic [IW-1:0]  r_idx,     n_idx;
    logic           r_last,    n_last;
    t_sample        r_va,      n_va;
    t_sample        r_vb,      n_vb;
    logic           r_got_a,   n_got_a;
    logic           r_got_b,   n_got_b;
    logic           r_m_valid, n_m_valid;
    t_sample        r_m_data,  n_m_data;
    logic           r_m_last,  n_m_last;

    logic                     in_xfer;
    logic                     out_free;
    logic [KW-1:0]            k_in;
    logic [KW-1:0]            fill_inc;
    logic [KW-1:0]            pos_a;
    logic [KW-1:0]            pos_b;
    logic signed [SAMPLE_W:0] mid_sum;
    logic signed [SAMPLE_W:0] mid_half;
    t_sample [MAX_WINDOW-1:0] taps;
    logic                     rk_vld;
    t_sample                  rk_value;
    logic                     rk_hit_a;
    logic                     rk_hit_b;

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_m_valid || m_axis_tready;

    // Sorted positions of the two middle values (equal for an odd window)
    assign pos_a = (r_k - KW'(1)) >> 1;
    assign pos_b = r_k >> 1;

    smf_window #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_window (
        .i_clk    (i_clk),
        .i_shift  (in_xfer),
        .i_sample (t_sample'(s_axis_tdata)),
        .o_taps   (taps)
    );

    smf_rank #(
        .MAX_WINDOW (MAX_WINDOW),
        .KW         (KW),
        .IW         (IW)
    ) u_rank (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_issue (r_state == S_SCAN),
        .i_idx   (r_idx),
        .i_k     (r_k),
        .i_pos_a (pos_a),
        .i_pos_b (pos_b),
        .i_taps  (taps),
        .o_vld   (rk_vld),
        .o_value (rk_value),
        .o_hit_a (rk_hit_a),
        .o_hit_b (rk_hit_b)
    );

    // Average of the middle pair, truncated toward zero
    always_comb begin
        mid_sum  = $signed({r_va[SAMPLE_W-1], r_va}) + $signed({r_vb[SAMPLE_W-1], r_vb});
        mid_half = (mid_sum + $signed({{SAMPLE_W{1'b0}}, mid_sum[SAMPLE_W]})) >>> 1;
    end

    // Sequencer next state
    always_comb begin
        n_state   = r_state;
        n_wsize   = r_wsize;
        n_fill    = r_fill;
        n_k       = r_k;
        n_idx     = r_idx;
        n_last    = r_last;
        n_va      = r_va;
        n_vb      = r_vb;
        n_got_a   = r_got_a;
        n_got_b   = r_got_b;
        n_m_valid = r_m_valid;
        n_m_data  = r_m_data;
        n_m_last  = r_m_last;

        k_in     = f_clamp(r_wsize);
        fill_inc = (r_fill < KW'(MAX_WINDOW)) ? (r_fill + KW'(1)) : r_fill;

        if (i_cfg_wr_en) begin
            n_wsize = i_cfg_wr_data;
        end

        // Drop the output once taken
        if (r_m_valid && m_axis_tready) begin
            n_m_valid = 1'b0;
        end

        // Capture ranked values that cover the wanted positions
        if (rk_vld && rk_hit_a) begin
            n_va    = rk_value;
            n_got_a = 1'b1;
        end
        if (rk_vld && rk_hit_b) begin
            n_vb    = rk_value;
            n_got_b = 1'b1;
        end

        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_fill  = s_axis_tlast ? KW'(0) : fill_inc;
                    n_k     = k_in;
                    n_last  = s_axis_tlast;
                    n_idx   = '0;
                    n_got_a = 1'b0;
                    n_got_b = 1'b0;
                    if (fill_inc >= k_in) begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (KW'(r_idx) == r_k - KW'(1)) begin
                    n_state = S_DRAIN;
                end else begin
                    n_idx = r_idx + IW'(1);
                end
            end
            S_DRAIN: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_m_valid = 1'b1;
                    n_m_data  = t_sample'(mid_half[SAMPLE_W-1:0]);
                    n_m_last  = r_last;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State, control and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_wsize   <= t_cfg'(CFG_RESET);
            r_fill    <= '0;
            r_k       <= KW'(1);
            r_idx     <= '0;
            r_got_a   <= 1'b0;
            r_got_b   <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_wsize   <= n_wsize;
            r_fill    <= n_fill;
            r_k       <= n_k;
            r_idx     <= n_idx;
            r_got_a   <= n_got_a;
            r_got_b   <= n_got_b;
            r_m_valid <= n_m_valid;
        end
        r_last   <= n_last;
        r_va     <= n_va;
        r_vb     <= n_vb;
        r_m_data <= n_m_data;
        r_m_last <= n_m_last;
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tlast  = r_m_last;

    // Fill count never passes the line length
    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= KW'(MAX_WINDOW))
        else $error("fill count beyond window line");

    // Scan index stays inside the active window
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (KW'(r_idx) < r_k))
        else $error("scan index outside window");

    // The rank stage delivers the last candidate during the drain cycle
    a_drain_vld: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAIN) |-> rk_vld)
        else $error("rank result missing in drain");

    // Both middle values are found before the result is formed
    a_hits_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |-> (r_got_a && r_got_b))
        else $error("middle value not located");

    // A new item is taken only once the previous one left the sequencer
    a_busy_after_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |=> !s_axis_tready)
        else $error("input ready during ranking");

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Streams signed samples through the sliding median filter. A queue-fed
// driver and a clocked monitor run alongside an in-bench window model that
// predicts every median and its end-of-sequence flag. Directed corner cases
// come first. Random sequences follow under many window settings, with
// random stalls on both sides and a long receiver hold-off.
// ----------------------------------------------------------------------------
module testbench;
    import smf_pkg::*;

    localparam int     MAX_WIN       = 16;
    localparam int     SETTLE_CYCLES = 40;
    localparam int     PHASES        = 16;
    localparam int     PHASE_ITEMS   = 80;
    localparam t_sample SMP_MAX      = 24'sh7FFFFF;
    localparam t_sample SMP_MIN      = 24'sh800000;

    typedef struct {
        t_sample sample;
        logic    eos;
    } t_sample_item;

    typedef struct {
        t_sample median;
        logic    last;
    } t_median;

    // Clock, reset and block ports
    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                i_cfg_wr_en   = 1'b0;
    logic [CFG_W-1:0]    i_cfg_wr_data = '0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [SAMPLE_W-1:0] s_axis_tdata  = '0;   // [23:0] sample
    logic                s_axis_tlast  = 1'b0; // end_of_sequence
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [SAMPLE_W-1:0] m_axis_tdata;         // [23:0] median
    logic                m_axis_tlast;         // last

    // Stimulus and expectation stores
    t_sample_item pending_samples[$];
    t_median      expected_medians[$];
    t_sample_item src_item;

    // Window model state
    t_sample win_hist[MAX_WIN];
    int      win_fill;
    t_cfg    win_size;

    // Flow control
    bit src_taken;
    bit gaps_on;
    int src_gap;
    int rcv_stall;
    int rcv_hold;
    int rcv_hold_req;

    // Bookkeeping
    int      n_err;
    int      n_in;
    int      n_out;
    int      n_eos;
    bit [31:0] sizes_written;
    t_cfg    win_plan[12];

    sliding_median_filter #(
        .MAX_WINDOW (MAX_WIN)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Clock generation
    always #5 i_clk = ~i_clk;

    // Pick an idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        if (!gaps_on) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Shift a sample into the window and queue the median it yields, if any
    function automatic void predict_median(t_sample smp, logic eos);
        t_sample sorted[MAX_WIN];
        t_sample v;
        t_median m;
        int      k;
        int      j;
        int      sum;
        k = (win_size == 0) ? 1 : (win_size > MAX_WIN) ? MAX_WIN : int'(win_size);
        for (int i = MAX_WIN - 1; i > 0; i--) win_hist[i] = win_hist[i-1];
        win_hist[0] = smp;
        if (win_fill < MAX_WIN) win_fill++;
        if (win_fill >= k) begin
            // insertion sort, ascending
            for (int i = 0; i < k; i++) begin
                v = win_hist[i];
                j = i;
                while (j > 0 && sorted[j-1] > v) begin
                    sorted[j] = sorted[j-1];
                    j--;
                end
                sorted[j] = v;
            end
            if (k % 2) begin
                m.median = sorted[(k-1)/2];
            end else begin
                // int division truncates toward zero
                sum = int'(sorted[k/2-1]) + int'(sorted[k/2]);
                m.median = t_sample'(sum / 2);
            end
            m.last = eos;
            expected_medians.push_back(m);
        end
        if (eos) win_fill = 0;
    endfunction

    task automatic flag_error(string msg);
        n_err++;
        if (n_err <= 10) $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    // Monitor: track config writes, predict on input transfers, check outputs
    always @(posedge i_clk) begin
        t_median exp_m;
        src_taken = 1'b0;
        if (!i_rst_n) begin
            win_fill = 0;
            win_size = t_cfg'(CFG_RESET);
        end else begin
            if (i_cfg_wr_en) win_size = i_cfg_wr_data;
            if (s_axis_tvalid && s_axis_tready) begin
                src_taken = 1'b1;
                n_in++;
                if (s_axis_tlast) n_eos++;
                predict_median(t_sample'(s_axis_tdata), s_axis_tlast);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                n_out++;
                if (expected_medians.size() == 0) begin
                    flag_error($sformatf("unexpected median %0d last %0b",
                                         $signed(m_axis_tdata), m_axis_tlast));
                end else begin
                    exp_m = expected_medians.pop_front();
                    if (m_axis_tdata !== exp_m.median)
                        flag_error($sformatf("median exp %0d got %0d", exp_m.median,
                                             $signed(m_axis_tdata)));
                    if (m_axis_tlast !== exp_m.last)
                        flag_error($sformatf("last exp %0b got %0b (median %0d)",
                                             exp_m.last, m_axis_tlast, exp_m.median));
                end
            end
        end
    end

    // Driver: present queued samples, hold each until its transfer completes
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            src_gap = 0;
        end else if (!s_axis_tvalid || src_taken) begin
            if (src_gap > 0) begin
                src_gap--;
                s_axis_tvalid <= 1'b0;
            end else if (pending_samples.size() > 0) begin
                src_item = pending_samples.pop_front();
                s_axis_tdata  <= src_item.sample;
                s_axis_tlast  <= src_item.eos;
                s_axis_tvalid <= 1'b1;
                src_gap = pick_gap();
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls plus an occasional long hold-off
    always @(negedge i_clk) begin
        if (rcv_hold_req > 0) begin
            rcv_hold = rcv_hold_req;
            rcv_hold_req = 0;
        end
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (rcv_hold > 0) begin
            rcv_hold--;
            m_axis_tready <= 1'b0;
        end else if (rcv_stall > 0) begin
            rcv_stall--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            rcv_stall = pick_gap();
        end
    end

    task automatic push_item(t_sample smp, logic eos);
        pending_samples.push_back('{smp, eos});
    endtask

    // Wait until every queued sample is taken and every median has come out
    task automatic drain_block();
        while (pending_samples.size() != 0 || s_axis_tvalid || expected_medians.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_window(t_cfg val);
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= val;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        sizes_written[val] = 1'b1;
        @(posedge i_clk);
    endtask

    // Stimulus
    initial begin
        int      k;
        int      left;
        int      len;
        bit      cut;
        bit      noisy;
        logic    eos;
        t_sample smp;
        t_cfg    w;

        win_plan = '{5'd1, 5'd2, 5'd16, 5'd31, 5'd3, 5'd17,
                     5'd4, 5'd0, 5'd8, 5'd7, 5'd15, 5'd6};
        gaps_on = 1'b1;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset window of five: extremes, then a sequence too short to fill
        push_item(SMP_MAX, 1'b0);
        push_item(SMP_MIN, 1'b0);
        push_item(24'sd0, 1'b0);
        push_item(-24'sd1, 1'b0);
        push_item(24'sd1, 1'b0);
        push_item(SMP_MAX, 1'b0);
        push_item(SMP_MIN, 1'b1);
        push_item(24'sd7, 1'b0);
        push_item(24'sd8, 1'b0);
        push_item(24'sd9, 1'b1);
        drain_block();

        // Zero size acts as a window of one
        write_window(5'd0);
        push_item(SMP_MAX, 1'b0);
        push_item(SMP_MIN, 1'b1);
        drain_block();

        // Even window: extreme sums and truncation toward zero
        write_window(5'd2);
        push_item(SMP_MIN, 1'b0);
        push_item(SMP_MIN, 1'b0);
        push_item(SMP_MAX, 1'b0);
        push_item(-24'sd3, 1'b0);
        push_item(24'sd0, 1'b0);
        push_item(SMP_MIN, 1'b1);
        drain_block();

        // Random phases; a phase may stop mid-sequence so the next size
        // applies to samples already held
        for (int p = 0; p < PHASES; p++) begin
            w = (p < 12) ? win_plan[p] : t_cfg'($urandom_range(0, 31));
            k = (w == 0) ? 1 : (w > MAX_WIN) ? MAX_WIN : int'(w);
            gaps_on = (p % 4 != 3);
            write_window(w);
            left = PHASE_ITEMS;
            while (left > 0) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5, 6: len = k + $urandom_range(0, 2 * k + 4);
                    7, 8:                len = $urandom_range(1, k);
                    default:             len = $urandom_range(1, 40);
                endcase
                noisy = (len > 0) && ($urandom_range(0, 9) == 0);
                cut = (len > left);
                if (cut) len = left;
                for (int i = 0; i < len; i++) begin
                    case ($urandom_range(0, 9))
                        0:       smp = SMP_MAX;
                        1:       smp = SMP_MIN;
                        2, 3, 4: smp = t_sample'(int'($urandom_range(0, 16)) - 8);
                        default: smp = t_sample'($urandom());
                    endcase
                    eos = noisy ? ($urandom_range(0, 3) == 0) : (i == len - 1 && !cut);
                    push_item(smp, eos);
                end
                left -= len;
            end
            // long hold-off on the output while the sender keeps offering
            if (p == 4) begin
                gaps_on = 1'b0;
                rcv_hold_req = 400;
            end
            drain_block();
        end

        $display("Covered %0d samples in, %0d medians out, %0d sequence ends.",
                 n_in, n_out, n_eos);
        $display("Window register took %0d distinct values, incl. 0, 1, 16 and above 16.",
                 $countones(sizes_written));
        if (n_err == 0 && expected_medians.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #10_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> sim.f
sv/smf_pkg.sv
sv/smf_window.sv
sv/smf_rank.sv
sv/sliding_median_filter.sv
sim/testbench.sv
